// ===== hw/rtl/ghist_pkg.sv =====
// Package for the gray-level histogram engine: sizes, opcodes and the
// bin store write beat type. Used by ghist_mem and gray_histogram_256.
package ghist_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 32;
    localparam int INDEX_BITS = $clog2(BIN_COUNT);
    localparam int VALUE_BITS = 8;
    localparam int OUT_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic
    {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic                  en;
        logic [INDEX_BITS-1:0] addr;
        logic [COUNT_BITS-1:0] data;
    } bin_wr_t;

endpackage

// ===== hw/rtl/ghist_mem.sv =====
// Bin count store: one synchronous RAM with a registered read plus
// per-entry valid flags cleared at reset. Depends on ghist_pkg.
module ghist_mem
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ghist_pkg::INDEX_BITS-1:0] rd_addr,
    output logic [ghist_pkg::COUNT_BITS-1:0] rd_data,
    input  ghist_pkg::bin_wr_t               wr
);
    import ghist_pkg::*;

    logic [COUNT_BITS-1:0] mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]  vld_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/gray_histogram_256.sv =====
// Top level of the gray-level histogram engine: read-modify-write pipeline
// around the bin store. Depends on ghist_pkg and ghist_mem.
//
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  op, value
// output   out        out_valid / out_stall bin_count, bin_index
//
// A pixel beat passes through the store read and then the write-back; pixels
// stream at one per cycle while the input is not stalled, with same-bin beats
// forwarded from the write stage. A read beat blocks the input while it sits
// in the write stage, its result landing in the output register meanwhile.
// Reset clears all bins at once through the store's valid flags.
// in_stall rises while the output register holds an untaken beat or a read beat is in the write stage.
module gray_histogram_256
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [ghist_pkg::VALUE_BITS-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ghist_pkg::OUT_BITS-1:0]   bin_count,
    output logic [ghist_pkg::VALUE_BITS-1:0] bin_index
);
    import ghist_pkg::*;

    logic                  in_accept;
    logic                  s2_valid_reg;
    op_t                   s2_op_reg;
    logic [VALUE_BITS-1:0] s2_value_reg;
    logic                  fwd_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  in_range;
    bin_wr_t               wr;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   bin_count_reg;
    logic [VALUE_BITS-1:0] bin_index_reg;
    logic                  out_load;

    assign in_stall  = (out_valid_reg && out_stall) || (s2_valid_reg && s2_op_reg == OP_READ);
    assign in_accept = in_valid && !in_stall;

    ghist_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (value[INDEX_BITS-1:0]),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign in_range  = 32'(s2_value_reg) < 32'(BIN_COUNT);
    assign cur_count = fwd_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        wr.en   = s2_valid_reg && in_range;
        wr.addr = s2_value_reg[INDEX_BITS-1:0];
        wr.data = '0;
        case (s2_op_reg)
            OP_COUNT:
            begin
                wr.data = (cur_count == COUNT_MAX) ? cur_count
                                                   : cur_count + COUNT_BITS'(1);
            end
            default:
            begin
                wr.data = '0;
            end
        endcase
    end

    assign out_load = s2_valid_reg && s2_op_reg == OP_READ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_accept;
            fwd_reg      <= wr.en && (wr.addr == value[INDEX_BITS-1:0]);
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_op_reg    <= op_t'(op);
            s2_value_reg <= value;
        end
        fwd_data_reg <= wr.data;
        if (out_load)
        begin
            bin_count_reg <= in_range ? OUT_BITS'(cur_count) : '0;
            bin_index_reg <= s2_value_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_count = bin_count_reg;
    assign bin_index = bin_index_reg;

    a_read_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_READ) |-> ##2 out_valid)
        else $error("read beat produced no result");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwrites a stalled beat");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(s2_valid_reg))
        else $error("forward without a preceding write");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for gray_histogram_256: directed table, then random pixel and read beats.
// Read results are checked against a bin-count predictor, or a table row's fixed count.
// Depends on ghist_pkg and the gray_histogram_256 RTL.
module tb;
    import ghist_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_ROWS    = 24;
    localparam int SEG_ITEMS   = 80;

    typedef struct
    {
        op_t                   op;
        logic [VALUE_BITS-1:0] value;
        bit                    fixed;
        logic [OUT_BITS-1:0]   count;
    } hist_row_t;

    typedef struct
    {
        logic [OUT_BITS-1:0]   count;
        logic [VALUE_BITS-1:0] index;
    } bin_read_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    op_t                   op        = OP_COUNT;
    logic [VALUE_BITS-1:0] value     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [OUT_BITS-1:0]   bin_count;
    logic [VALUE_BITS-1:0] bin_index;

    logic [COUNT_BITS-1:0] bin_model [BIN_COUNT];
    bin_read_t             pending_reads [$];
    int                    mismatches  = 0;
    int                    cycles      = 0;
    int                    stall_left  = 0;
    bit                    in_idle_en  = 1'b0;
    bit                    out_idle_en = 1'b0;

    hist_row_t hist_rows [NUM_ROWS] = '{
        '{OP_READ,  8'd0,   1'b1, 32'd0},
        '{OP_READ,  8'd255, 1'b1, 32'd0},
        '{OP_COUNT, 8'd0,   1'b0, 32'd0},
        '{OP_COUNT, 8'd0,   1'b0, 32'd0},
        '{OP_COUNT, 8'd0,   1'b0, 32'd0},
        '{OP_COUNT, 8'd255, 1'b0, 32'd0},
        '{OP_COUNT, 8'd255, 1'b0, 32'd0},
        '{OP_READ,  8'd0,   1'b1, 32'd3},
        '{OP_READ,  8'd255, 1'b1, 32'd2},
        '{OP_READ,  8'd0,   1'b1, 32'd0},
        '{OP_COUNT, 8'hAA,  1'b0, 32'd0},
        '{OP_COUNT, 8'h55,  1'b0, 32'd0},
        '{OP_READ,  8'hAA,  1'b1, 32'd1},
        '{OP_READ,  8'h55,  1'b1, 32'd1},
        '{OP_COUNT, 8'd128, 1'b0, 32'd0},
        '{OP_READ,  8'd128, 1'b1, 32'd1},
        '{OP_COUNT, 8'd1,   1'b0, 32'd0},
        '{OP_COUNT, 8'd2,   1'b0, 32'd0},
        '{OP_COUNT, 8'd1,   1'b0, 32'd0},
        '{OP_READ,  8'd1,   1'b0, 32'd0},
        '{OP_READ,  8'd2,   1'b0, 32'd0},
        '{OP_COUNT, 8'd127, 1'b0, 32'd0},
        '{OP_READ,  8'd127, 1'b0, 32'd0},
        '{OP_READ,  8'd127, 1'b1, 32'd0}
    };

    gray_histogram_256 dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_count (bin_count),
        .bin_index (bin_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function automatic bit tally_beat(input op_t o, input logic [VALUE_BITS-1:0] v,
                                      output bin_read_t r);
        r.index = v;
        r.count = '0;
        if (o == OP_COUNT)
        begin
            if (32'(v) < BIN_COUNT && bin_model[v] != COUNT_MAX)
                bin_model[v] = bin_model[v] + COUNT_BITS'(1);
            return 1'b0;
        end
        if (32'(v) < BIN_COUNT)
        begin
            r.count     = bin_model[v][OUT_BITS-1:0];
            bin_model[v] = '0;
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input op_t o, input logic [VALUE_BITS-1:0] v,
                             input bit fixed, input logic [OUT_BITS-1:0] fixed_count);
        bin_read_t r;
        if (in_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tally_beat(o, v, r))
        begin
            if (fixed)
                r.count = fixed_count;
            pending_reads.push_back(r);
        end
    endtask

    task automatic drain_reads();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_segment(input int n, input bit idle_in, input bit idle_out);
        logic [VALUE_BITS-1:0] hot [4];
        logic [VALUE_BITS-1:0] v;
        op_t                   o;
        int                    pick;
        in_idle_en  = idle_in;
        out_idle_en = idle_out;
        foreach (hot[i])
            hot[i] = VALUE_BITS'($urandom_range(0, 255));
        v = hot[0];
        for (int i = 0; i < n; i++)
        begin
            o    = ($urandom_range(0, 99) < 25) ? OP_READ : OP_COUNT;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                v = hot[$urandom_range(0, 3)];
            else if (pick >= 55)
                v = VALUE_BITS'($urandom_range(0, 255));
            send_beat(o, v, 1'b0, '0);
        end
        drain_reads();
    endtask

    always @(posedge clk)
    begin
        bin_read_t exp_read;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch($sformatf("unexpected result, bin %0d count %0d",
                                          bin_index, bin_count));
            else
            begin
                exp_read = pending_reads.pop_front();
                if (bin_count !== exp_read.count)
                    report_mismatch($sformatf("bin %0d: count %0d, want %0d",
                                              exp_read.index, bin_count, exp_read.count));
                if (bin_index !== exp_read.index)
                    report_mismatch($sformatf("bin index %0d, want %0d",
                                              bin_index, exp_read.index));
            end
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (out_idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        foreach (bin_model[i])
            bin_model[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (hist_rows[i])
            send_beat(hist_rows[i].op, hist_rows[i].value, hist_rows[i].fixed,
                      hist_rows[i].count);
        drain_reads();

        run_segment(SEG_ITEMS, 1'b1, 1'b1);
        run_segment(SEG_ITEMS, 1'b1, 1'b0);
        run_segment(SEG_ITEMS, 1'b0, 1'b1);
        run_segment(SEG_ITEMS, 1'b1, 1'b1);
        run_segment(SEG_ITEMS, 1'b0, 1'b0);

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
